FILE: src/shd_pkg.sv
`default_nettype none
package shd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned ORDER_W = 2;

  // absolute day number of any 14-bit year fits in 23 bits
  localparam int unsigned DAYNUM_W = 23;
  // quotient of year by the cycle length
  localparam int unsigned QUOT_W   = 9;
  localparam int unsigned REM_W    = 6;
  localparam int unsigned PROD_W   = 25;

  localparam int unsigned CYCLE_YEARS     = 33;
  localparam int unsigned LEAPS_PER_CYCLE = 8;
  localparam int unsigned YEAR_DAYS       = 365;

  // floor(y / 33) == (y * 1986) >> 16 holds for every 14-bit year
  localparam logic [PROD_W-1:0] QMUL   = PROD_W'(1986);
  localparam int unsigned       QSHIFT = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [ORDER_W-1:0] ORD_EARLIER = 2'd0;
  localparam logic [ORDER_W-1:0] ORD_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORD_LATER   = 2'd2;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                err;
    logic [DAYNUM_W-1:0] n1;
    logic [DAYNUM_W-1:0] n2;
  } rec_t;

  function automatic logic leap_of(input logic [REM_W-1:0] r);
    logic res;
    case (r)
      6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  // leap years in the cycle before position r
  function automatic logic [3:0] cum_leaps(input logic [REM_W-1:0] r);
    logic [3:0] c;
    c = 4'(r > 6'd1) + 4'(r > 6'd5) + 4'(r > 6'd9) + 4'(r > 6'd13)
      + 4'(r > 6'd17) + 4'(r > 6'd22) + 4'(r > 6'd26) + 4'(r > 6'd30);
    return c;
  endfunction

  // days before the first of month m (valid months only)
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] off;
    if (m <= 4'd7) begin
      off = 9'(m - 4'd1) * 9'd31;
    end else begin
      off = 9'd186 + 9'(m - 4'd7) * 9'd30;
    end
    return off;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m <= 4'd6) begin
      len = 5'd31;
    end else if (m <= 4'd11) begin
      len = 5'd30;
    end else begin
      len = leap ? 5'd30 : 5'd29;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: src/solar_hijri_day_span_top.sv
// inclusive day span between two solar hijri dates
//
// input channel: in_valid_i / in_ready_o with both dates as separate ports;
// an item transfers on a rising edge with valid and ready both high
// output channel: out_valid_o / out_ready_i with day_count_o, order_o and
// date_error_o; one result per input item, in input order
//
// the front sequencer (capture, divide year by 33, build day numbers) holds
// one item at a time and takes no new item until it has pushed the last one
// into the queue; the day count is a difference of absolute day numbers
//
// a queue of QUEUE_DEPTH entries sits between front and back, so the front
// keeps accepting while the back holds a result the receiver has not taken;
// when the receiver stalls the queue fills and in_ready_o then drops
//
// reset: queue and output register are empty, in_ready_o is high right away
`default_nettype none
module solar_hijri_day_span_top import shd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [DAY_W-1:0]   first_day_i,
  input  wire logic [MONTH_W-1:0] first_month_i,
  input  wire logic [YEAR_W-1:0]  first_year_i,
  input  wire logic [DAY_W-1:0]   second_day_i,
  input  wire logic [MONTH_W-1:0] second_month_i,
  input  wire logic [YEAR_W-1:0]  second_year_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [COUNT_W-1:0]      day_count_o,
  output logic [ORDER_W-1:0]      order_o,
  output logic                    date_error_o
);

  // front to queue
  logic push;
  rec_t push_rec;
  logic full;

  // queue to back
  logic q_valid;
  rec_t q_rec;
  logic pop;

  // validates both dates and turns them into day numbers
  shd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_day_i   (first_day_i),
    .first_month_i (first_month_i),
    .first_year_i  (first_year_i),
    .second_day_i  (second_day_i),
    .second_month_i(second_month_i),
    .second_year_i (second_year_i),
    .push_o        (push),
    .rec_o         (push_rec),
    .full_i        (full)
  );

  // decouples front from a stalled receiver
  shd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (full),
    .valid_o(q_valid),
    .rec_o  (q_rec),
    .pop_i  (pop)
  );

  // order, span and saturation into the output register
  shd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .rec_i       (q_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .day_count_o (day_count_o),
    .order_o     (order_o),
    .date_error_o(date_error_o)
  );

`ifndef SYNTH
  // an error result carries zero count and zero order
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && date_error_o) |-> (day_count_o == '0 && order_o == ORD_EARLIER))
    else $error("error result with nonzero fields");

  // a good result always counts at least one day
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !date_error_o) |-> (day_count_o != '0))
    else $error("valid result with zero count");

  // equal dates give exactly one day
  a_equal_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !date_error_o && order_o == ORD_EQUAL) |-> (day_count_o == COUNT_W'(1)))
    else $error("equal dates without count of one");

  // the front is busy right after a transfer
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("front ready right after transfer");
`endif

endmodule
`default_nettype wire

FILE: src/shd_front.sv
`default_nettype none
module shd_front import shd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [DAY_W-1:0]   first_day_i,
  input  wire logic [MONTH_W-1:0] first_month_i,
  input  wire logic [YEAR_W-1:0]  first_year_i,
  input  wire logic [DAY_W-1:0]   second_day_i,
  input  wire logic [MONTH_W-1:0] second_month_i,
  input  wire logic [YEAR_W-1:0]  second_year_i,
  output logic                    push_o,
  output rec_t                    rec_o,
  input  wire logic               full_i
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_CALC} state_e;

  typedef struct packed {
    logic                ok;
    logic [DAYNUM_W-1:0] n;
  } info_t;

  state_e             state_q;
  date_t              a_q, b_q;
  logic [QUOT_W-1:0]  qa_q, qb_q;
  logic [QUOT_W-1:0]  qa_d, qb_d;
  info_t              ia, ib;

  function automatic info_t eval_date(input date_t dt, input logic [QUOT_W-1:0] q);
    logic [YEAR_W-1:0] q33;
    logic [REM_W-1:0]  r;
    logic              leap;
    info_t             res;
    q33  = {q, 5'b0} + YEAR_W'(q);
    r    = REM_W'(dt.year - q33);
    leap = leap_of(r);
    res.ok = (dt.month >= 4'd1) && (dt.month <= 4'd12) && (dt.day >= 5'd1)
          && (dt.day <= month_len(dt.month, leap));
    res.n  = DAYNUM_W'(dt.year) * DAYNUM_W'(YEAR_DAYS)
           + DAYNUM_W'({q, 3'b0})
           + DAYNUM_W'(cum_leaps(r))
           + DAYNUM_W'(month_offset(dt.month))
           + DAYNUM_W'(dt.day) - DAYNUM_W'(1);
    return res;
  endfunction

  // year / 33 by reciprocal
  assign qa_d = QUOT_W'((PROD_W'(a_q.year) * QMUL) >> QSHIFT);
  assign qb_d = QUOT_W'((PROD_W'(b_q.year) * QMUL) >> QSHIFT);

  assign ia = eval_date(a_q, qa_q);
  assign ib = eval_date(b_q, qb_q);

  assign in_ready_o = (state_q == F_IDLE);
  assign push_o     = (state_q == F_CALC) && !full_i;
  assign rec_o.err  = !(ia.ok && ib.ok);
  assign rec_o.n1   = ia.n;
  assign rec_o.n2   = ib.n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: if (in_valid_i) state_q <= F_DIV;
        F_DIV:  state_q <= F_CALC;
        F_CALC: if (!full_i) state_q <= F_IDLE;
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= '{day: first_day_i, month: first_month_i, year: first_year_i};
      b_q <= '{day: second_day_i, month: second_month_i, year: second_year_i};
    end
    if (state_q == F_DIV) begin
      qa_q <= qa_d;
      qb_q <= qb_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/shd_fifo.sv
`default_nettype none
module shd_fifo import shd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rec_t rec_i,
  output logic      full_o,
  output logic      valid_o,
  output rec_t      rec_o,
  input  wire logic pop_i
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  rec_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LAST) ? '0 : wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= (rd_q == LAST) ? '0 : rd_q + PTR_W'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

endmodule
`default_nettype wire

FILE: src/shd_back.sv
`default_nettype none
module shd_back import shd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire rec_t        rec_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [COUNT_W-1:0] day_count_o,
  output logic [ORDER_W-1:0] order_o,
  output logic             date_error_o
);

  logic                 out_valid_q;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [ORDER_W-1:0]   order_q, order_d;
  logic                 err_q;
  logic [DAYNUM_W-1:0]  diff;
  logic [DAYNUM_W:0]    span;

  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    if (rec_i.n1 < rec_i.n2) begin
      order_d = ORD_EARLIER;
      diff    = rec_i.n2 - rec_i.n1;
    end else if (rec_i.n1 == rec_i.n2) begin
      order_d = ORD_EQUAL;
      diff    = '0;
    end else begin
      order_d = ORD_LATER;
      diff    = rec_i.n1 - rec_i.n2;
    end
    span = {1'b0, diff} + (DAYNUM_W+1)'(1);
    if (span > (DAYNUM_W+1)'(COUNT_MAX)) begin
      count_d = COUNT_MAX;
    end else begin
      count_d = COUNT_W'(span);
    end
    // bad date: zero count and order field
    if (rec_i.err) begin
      order_d = ORD_EARLIER;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      count_q <= count_d;
      order_q <= order_d;
      err_q   <= rec_i.err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign day_count_o  = count_q;
  assign order_o      = order_q;
  assign date_error_o = err_q;

endmodule
`default_nettype wire
